@@ hdl/mikl_pkg.sv @@
// Shared types and constants for the mecanum inverse kinematics limit unit.
`timescale 1ns / 1ps

package mikl_pkg;

  localparam int VEL_W  = 16;              // command field width
  localparam int CFG_W  = 16;              // widest register
  localparam int LIM_W  = 15;              // speed limit width
  localparam int LIN_W  = 34;              // signed wheel surface speed, 20 fraction bits
  localparam int MAG_W  = LIN_W - 1;       // its magnitude
  localparam int PROD_W = MAG_W + CFG_W;   // shared multiplier product
  localparam int FRAC_W = 28;              // fraction bits dropped after the gain
  localparam int MOT_W  = PROD_W - FRAC_W; // motor speed magnitude before limiting
  localparam int QUOT_W = LIM_W;           // scaled speed never exceeds the limit
  localparam int DIV_W  = MOT_W + QUOT_W;  // dividend of the scaling divide
  localparam int IDX_W  = 2;               // register index and wheel index
  localparam int OUT_W  = 16;

  localparam logic [IDX_W-1:0] CFG_WHEEL_GEOMETRY = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SPEED_GAIN     = 2'd1;
  localparam logic [IDX_W-1:0] CFG_SPEED_LIMIT    = 2'd2;

  localparam logic [CFG_W-1:0] WHEEL_GEOMETRY_RST = 16'd7680;
  localparam logic [CFG_W-1:0] SPEED_GAIN_RST     = 16'd4096;
  localparam logic [LIM_W-1:0] SPEED_LIMIT_RST    = 15'd8000;

  localparam logic [IDX_W-1:0] LAST_WHEEL = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_MUL,
    ST_ROT_TAKE,
    ST_GAIN_MUL,
    ST_GAIN_TAKE,
    ST_CHECK,
    ST_LIM_MUL,
    ST_LIM_TAKE,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [CFG_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [MOT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ hdl/mecanum_inverse_kinematics_limit_unit.sv @@
// Top level: mecanum wheel inverse kinematics with gain, speed limit and stop handling.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready) takes one chassis command item: vel_x, vel_y
//   (Q12.4 cm/s) and vel_rot (Q4.12 rad/s). Output channel (out_valid/out_ready)
//   returns action, motor_a..motor_d (rpm) and limited.
//   The config port (cfg_we, cfg_index, cfg_data) writes wheel_geometry, speed_gain
//   and speed_limit; write it only when no item is in flight.
// Sequencing
//   One shared multiplier does the rotation term, then the gain of each wheel.
//   The block takes no new item until the previous result has been loaded into
//   the output register. When the largest speed exceeds the limit, each wheel
//   also goes through one multiply and a 15-step restoring divide. An all-zero
//   command gives one stop result; repeats of it are accepted and dropped.
// Reset
//   rst clears the sequencer, the stop flag and the output valid, and loads the
//   register defaults (30.0 cm geometry, gain 16.0, limit 8000 rpm).
// Stalls
//   A finished result waits in the output register; the next item is taken
//   meanwhile and its own result holds in the last step until the register frees.
module mecanum_inverse_kinematics_limit_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mikl_pkg::VEL_W-1:0]   vel_x,
  input  logic signed [mikl_pkg::VEL_W-1:0]   vel_y,
  input  logic signed [mikl_pkg::VEL_W-1:0]   vel_rot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                action,
  output logic signed [mikl_pkg::OUT_W-1:0]   motor_a,
  output logic signed [mikl_pkg::OUT_W-1:0]   motor_b,
  output logic signed [mikl_pkg::OUT_W-1:0]   motor_c,
  output logic signed [mikl_pkg::OUT_W-1:0]   motor_d,
  output logic                                limited,
  input  logic                                cfg_we,
  input  logic [mikl_pkg::IDX_W-1:0]          cfg_index,
  input  logic [mikl_pkg::CFG_W-1:0]          cfg_data
);
  import mikl_pkg::*;

  // configuration
  logic [CFG_W-1:0] wheel_geometry;
  logic [CFG_W-1:0] speed_gain;
  logic [LIM_W-1:0] speed_limit;

  // sequencer
  state_t state;
  state_t state_next;
  logic   stopped;
  logic   accept;
  logic   zero_cmd;
  logic   out_free;
  logic   load_out;

  // command and intermediate values
  logic signed [VEL_W-1:0] vx;
  logic signed [VEL_W-1:0] vy;
  logic signed [VEL_W-1:0] vr;
  logic signed [LIN_W-1:0] rot;
  logic [IDX_W-1:0]        idx;
  logic [MOT_W-1:0]        m_mag [4];
  logic                    m_neg [4];
  logic [MOT_W-1:0]        maxv;
  logic                    lim_flag;
  logic                    stop_flag;

  // wheel sum datapath
  logic signed [VEL_W:0]   sum_xy;
  logic signed [VEL_W:0]   diff_xy;
  logic signed [LIN_W-1:0] base;
  logic signed [LIN_W-1:0] lin;
  logic [MAG_W-1:0]        lin_mag;
  logic [VEL_W-1:0]        vr_mag;
  logic [MOT_W-1:0]        gain_mot;

  // shared units
  mul_req_t          mul_req;
  logic [PROD_W-1:0] prod;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  function automatic logic signed [OUT_W-1:0] motor_word(input logic [MOT_W-1:0] m,
                                                         input logic neg);
    logic [OUT_W-1:0] mag;
    mag = (m > MOT_W'(16'h7fff)) ? 16'h7fff : {1'b0, m[OUT_W-2:0]};
    return neg ? -mag : mag;
  endfunction

  assign accept   = in_valid && in_ready;
  assign zero_cmd = (vel_x == '0) && (vel_y == '0) && (vel_rot == '0);
  assign out_free = !out_valid || out_ready;

  // wheel 1 and 2 use x + y, wheels 0 and 3 use x - y; even wheels add rotation
  assign sum_xy  = {vx[VEL_W-1], vx} + {vy[VEL_W-1], vy};
  assign diff_xy = {vx[VEL_W-1], vx} - {vy[VEL_W-1], vy};
  assign base    = (idx == 2'd1 || idx == 2'd2) ? {sum_xy[VEL_W], sum_xy, 16'b0}
                                                : {diff_xy[VEL_W], diff_xy, 16'b0};
  assign lin     = idx[0] ? (base - rot) : (base + rot);
  assign lin_mag = lin[LIN_W-1] ? MAG_W'(-lin) : lin[MAG_W-1:0];
  assign vr_mag  = vr[VEL_W-1] ? VEL_W'(-vr) : vr;
  // drop the 28 fraction bits: magnitude truncation is truncation toward zero
  assign gain_mot = prod[PROD_W-1:FRAC_W];

  mikl_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  mikl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers; index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_geometry <= WHEEL_GEOMETRY_RST;
      speed_gain     <= SPEED_GAIN_RST;
      speed_limit    <= SPEED_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_GEOMETRY: wheel_geometry <= cfg_data;
        CFG_SPEED_GAIN:     speed_gain     <= cfg_data;
        CFG_SPEED_LIMIT:    speed_limit    <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!zero_cmd) begin
            state_next = ST_ROT_MUL;
          end else if (!stopped) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_ROT_MUL:   state_next = ST_ROT_TAKE;
      ST_ROT_TAKE:  state_next = ST_GAIN_MUL;
      ST_GAIN_MUL:  state_next = ST_GAIN_TAKE;
      ST_GAIN_TAKE: state_next = (idx == LAST_WHEEL) ? ST_CHECK : ST_GAIN_MUL;
      ST_CHECK:     state_next = (maxv > MOT_W'(speed_limit)) ? ST_LIM_MUL : ST_DONE;
      ST_LIM_MUL:   state_next = ST_LIM_TAKE;
      ST_LIM_TAKE:  state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (idx == LAST_WHEEL) ? ST_DONE : ST_LIM_MUL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: operand select for the shared units
  always_comb begin
    in_ready         = 1'b0;
    load_out         = 1'b0;
    mul_req.a        = '0;
    mul_req.b        = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod[DIV_W-1:0];
    div_req.divisor  = maxv;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_ROT_MUL: begin
        mul_req.a = MAG_W'(vr_mag);
        mul_req.b = wheel_geometry;
      end
      ST_GAIN_MUL: begin
        mul_req.a = lin_mag;
        mul_req.b = speed_gain;
      end
      ST_LIM_MUL: begin
        mul_req.a = MAG_W'(m_mag[idx]);
        mul_req.b = CFG_W'(speed_limit);
      end
      ST_LIM_TAKE: div_req.start = 1'b1;
      ST_DONE:     load_out = out_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        stopped <= zero_cmd;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        vx        <= vel_x;
        vy        <= vel_y;
        vr        <= vel_rot;
        stop_flag <= zero_cmd;
        idx       <= '0;
        maxv      <= '0;
        lim_flag  <= 1'b0;
      end
      ST_ROT_TAKE: begin
        rot <= vr[VEL_W-1] ? -$signed({2'b00, prod[31:0]}) : $signed({2'b00, prod[31:0]});
      end
      ST_GAIN_MUL: begin
        // motors on wheels 0 and 2 turn the other way
        m_neg[idx] <= lin[LIN_W-1] ^ ~idx[0];
      end
      ST_GAIN_TAKE: begin
        m_mag[idx] <= gain_mot;
        if (gain_mot > maxv) begin
          maxv <= gain_mot;
        end
        idx <= idx + 2'd1;
      end
      ST_CHECK: begin
        lim_flag <= maxv > MOT_W'(speed_limit);
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          m_mag[idx] <= MOT_W'(div_rsp.quot);
          idx        <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      action  <= !stop_flag;
      limited <= !stop_flag && lim_flag;
      motor_a <= stop_flag ? '0 : motor_word(m_mag[0], m_neg[0]);
      motor_b <= stop_flag ? '0 : motor_word(m_mag[1], m_neg[1]);
      motor_c <= stop_flag ? '0 : motor_word(m_mag[2], m_neg[2]);
      motor_d <= stop_flag ? '0 : motor_word(m_mag[3], m_neg[3]);
    end
  end

  logic signed [OUT_W:0] lim_s;
  assign lim_s = {2'b00, speed_limit};

  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (motor_a <= lim_s && motor_a >= -lim_s && motor_b <= lim_s &&
                   motor_b >= -lim_s && motor_c <= lim_s && motor_c >= -lim_s &&
                   motor_d <= lim_s && motor_d >= -lim_s))
    else $error("motor speed above the speed limit");

  a_repeat_stop_dropped: assert property (@(posedge clk) disable iff (rst)
    (accept && zero_cmd && stopped) |=> (state == ST_IDLE))
    else $error("repeated zero command started work");

  a_divide_only_when_over: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_WAIT) |-> (lim_flag && maxv > MOT_W'(speed_limit)))
    else $error("scaling divide without the limit being exceeded");

  a_stop_result_clean: assert property (@(posedge clk) disable iff (rst)
    (load_out && stop_flag) |=> (out_valid && !action && !limited))
    else $error("stop result carries speeds");

endmodule

@@ hdl/mikl_mul.sv @@
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module mikl_mul (
  input  logic                          clk,
  input  mikl_pkg::mul_req_t            req,
  output logic [mikl_pkg::PROD_W-1:0]   prod
);
  import mikl_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(req.a) * PROD_W'(req.b);
  end

endmodule

@@ hdl/mikl_div.sv @@
// Restoring divider, one quotient bit per cycle, for the speed limit scaling.
`timescale 1ns / 1ps

module mikl_div (
  input  logic               clk,
  input  logic               rst,
  input  mikl_pkg::div_req_t req,
  output mikl_pkg::div_rsp_t rsp
);
  import mikl_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(QUOT_W);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  logic [CNT_W-1:0]  count;
  logic              done;
  logic [MOT_W-1:0]  rem;
  logic [MOT_W-1:0]  divisor;
  logic [QUOT_W-1:0] dlow;
  logic [QUOT_W-1:0] quot;
  logic [MOT_W:0]    trial;
  logic [MOT_W:0]    diff;
  logic              fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, dlow[QUOT_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        count <= STEPS;
      end else if (count != '0) begin
        count <= count - ONE;
        done  <= (count == ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.dividend[DIV_W-1:QUOT_W];
      dlow    <= req.dividend[QUOT_W-1:0];
      divisor <= req.divisor;
    end else if (count != '0) begin
      rem  <= fits ? diff[MOT_W-1:0] : trial[MOT_W-1:0];
      quot <= {quot[QUOT_W-2:0], fits};
      dlow <= {dlow[QUOT_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (rem < divisor))
    else $error("partial remainder reached the divisor");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (count == '0))
    else $error("divide started while one is in progress");

  a_done_after_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> ($past(count) == ONE))
    else $error("divide finished without its last step");

endmodule

@@ tb/tb_mecanum_inverse_kinematics_limit_unit.sv @@
// Testbench for the mecanum inverse kinematics unit: motor speed prediction and result checks.
`timescale 1ns / 1ps

module tb_mecanum_inverse_kinematics_limit_unit;
  import mikl_pkg::*;

  // Longest path through the block is a limited item. Allow some margin
  // after the last result before touching the registers or ending the run.
  localparam int DRAIN_CYCLES = 120;
  // Cycles with no handshake on either channel before the run is declared hung.
  // The slowest correct stretch is a limited item behind a receiver stall plus a
  // drain pause.
  localparam int QUIET_LIMIT  = 3000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 300;

  // Index 3 decodes to no register; writes there must leave everything unchanged.
  localparam logic [IDX_W-1:0] CFG_SPARE = 2'd3;

  localparam logic signed [VEL_W-1:0] EXTREMES [5] = '{16'sh8000, -16'sd1, 16'sd0,
                                                       16'sd1, 16'sh7FFF};

  typedef struct packed {
    logic             action;
    logic [OUT_W-1:0] ma;
    logic [OUT_W-1:0] mb;
    logic [OUT_W-1:0] mc;
    logic [OUT_W-1:0] md;
    logic             limited;
  } speed_set_t;

  // Motor speed predictor plus the queue of speed sets still owed by the block.
  class speed_board;
    longint     geometry;
    longint     gain;
    longint     limit_rpm;
    bit         stopped;
    speed_set_t pending_speeds[$];
    int         errors;
    int         results_checked;
    int         limited_results;
    int         stop_results;

    function new();
      geometry  = longint'(WHEEL_GEOMETRY_RST);
      gain      = longint'(SPEED_GAIN_RST);
      limit_rpm = longint'(SPEED_LIMIT_RST);
      stopped   = 1'b0;
    endfunction

    function void set_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        CFG_WHEEL_GEOMETRY: geometry  = longint'(data);
        CFG_SPEED_GAIN:     gain      = longint'(data);
        CFG_SPEED_LIMIT:    limit_rpm = longint'(data[LIM_W-1:0]);
        default: ;
      endcase
    endfunction

    // Work out the motor speeds for one command; returns 1 if a result is owed.
    function bit note_command(logic signed [VEL_W-1:0] cx, logic signed [VEL_W-1:0] cy,
                              logic signed [VEL_W-1:0] cr);
      longint     vx, vy, vr, px, mx, rot, peak;
      longint     lin [4];
      longint     spd [4];
      speed_set_t s;
      int         i;
      vx = longint'(cx);
      vy = longint'(cy);
      vr = longint'(cr);
      if (vx == 0 && vy == 0 && vr == 0) begin
        // one stop per run of zero commands
        if (stopped) return 1'b0;
        stopped = 1'b1;
        s = '0;
        pending_speeds.push_back(s);
        return 1'b1;
      end
      stopped = 1'b0;
      // wheel surface speeds, 20 fraction bits
      px  = (vx + vy) * 65536;
      mx  = (vx - vy) * 65536;
      rot = vr * geometry;
      lin[0] = mx + rot;
      lin[1] = px - rot;
      lin[2] = px + rot;
      lin[3] = mx - rot;
      // gain adds 8 more fraction bits; drop all 28 toward zero
      for (i = 0; i < 4; i++) spd[i] = (lin[i] * gain) / (longint'(1) << 28);
      spd[0] = -spd[0];
      spd[2] = -spd[2];
      peak = 0;
      for (i = 0; i < 4; i++) begin
        if (spd[i] > peak) peak = spd[i];
        if (-spd[i] > peak) peak = -spd[i];
      end
      s.limited = 1'b0;
      if (peak > limit_rpm) begin
        s.limited = 1'b1;
        for (i = 0; i < 4; i++) spd[i] = (spd[i] * limit_rpm) / peak;
      end
      for (i = 0; i < 4; i++) begin
        if (spd[i] > 32767) spd[i] = 32767;
        if (spd[i] < -32767) spd[i] = -32767;
      end
      s.action = 1'b1;
      s.ma = spd[0][OUT_W-1:0];
      s.mb = spd[1][OUT_W-1:0];
      s.mc = spd[2][OUT_W-1:0];
      s.md = spd[3][OUT_W-1:0];
      pending_speeds.push_back(s);
      return 1'b1;
    endfunction

    function void check_speeds(speed_set_t got);
      speed_set_t exp;
      if (pending_speeds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with nothing pending: action=%0d a=%0d b=%0d c=%0d d=%0d lim=%0d",
                   $realtime, got.action, $signed(got.ma), $signed(got.mb), $signed(got.mc),
                   $signed(got.md), got.limited);
        return;
      end
      exp = pending_speeds.pop_front();
      results_checked++;
      if (exp.limited) limited_results++;
      if (!exp.action) stop_results++;
      if (got.action !== exp.action || got.ma !== exp.ma || got.mb !== exp.mb ||
          got.mc !== exp.mc || got.md !== exp.md || got.limited !== exp.limited) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: result %0d differs", $realtime, results_checked);
          $display("  expected action=%0d a=%0d b=%0d c=%0d d=%0d lim=%0d", exp.action,
                   $signed(exp.ma), $signed(exp.mb), $signed(exp.mc), $signed(exp.md),
                   exp.limited);
          $display("  actual   action=%0d a=%0d b=%0d c=%0d d=%0d lim=%0d", got.action,
                   $signed(got.ma), $signed(got.mb), $signed(got.mc), $signed(got.md),
                   got.limited);
        end
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [VEL_W-1:0] vel_x = '0;
  logic signed [VEL_W-1:0] vel_y = '0;
  logic signed [VEL_W-1:0] vel_rot = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    action;
  logic signed [OUT_W-1:0] motor_a;
  logic signed [OUT_W-1:0] motor_b;
  logic signed [OUT_W-1:0] motor_c;
  logic signed [OUT_W-1:0] motor_d;
  logic                    limited;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  speed_board board = new();
  int         commands_sent;
  int         settings_used;
  bit         last_zero;
  bit         owed;

  mecanum_inverse_kinematics_limit_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_rot   (vel_rot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .motor_a   (motor_a),
    .motor_b   (motor_b),
    .motor_c   (motor_c),
    .motor_d   (motor_d),
    .limited   (limited),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Present one command at the falling edge and hold it until the block takes it.
  // The prediction is made at the accepting edge.
  task automatic send_command(input logic signed [VEL_W-1:0] x,
                              input logic signed [VEL_W-1:0] y,
                              input logic signed [VEL_W-1:0] r, output bit produced);
    @(negedge clk);
    in_valid <= 1'b1;
    vel_x    <= x;
    vel_y    <= y;
    vel_rot  <= r;
    do @(posedge clk); while (!in_ready);
    produced = board.note_command(x, y, r);
    commands_sent++;
  endtask

  // Drop valid and keep it low, with n setting how long.
  task automatic idle_sender(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Write a register at the next rising edge; the predictor takes it at once since
  // the block is idle whenever this runs.
  task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    board.set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold off until every owed result is in, then let dropped zero commands and any
  // trailing work settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_speeds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    settings_used++;
  endtask

  // Zero runs, moderate commands that stay under the default limit, single-axis moves,
  // extremes, and full-range noise.
  function automatic void pick_command(output logic signed [VEL_W-1:0] x,
                                       output logic signed [VEL_W-1:0] y,
                                       output logic signed [VEL_W-1:0] r);
    int kind;
    kind = $urandom_range(0, 99);
    x = '0;
    y = '0;
    r = '0;
    if ((last_zero && kind < 40) || kind < 10) begin
      // zero command, repeats favored right after one
    end else if (kind < 40) begin
      x = VEL_W'(int'($urandom_range(0, 4094)) - 2047);
      y = VEL_W'(int'($urandom_range(0, 4094)) - 2047);
      r = VEL_W'(int'($urandom_range(0, 8190)) - 4095);
    end else if (kind < 55) begin
      case ($urandom_range(0, 2))
        0:       x = VEL_W'($urandom);
        1:       y = VEL_W'($urandom);
        default: r = VEL_W'($urandom);
      endcase
    end else if (kind < 65) begin
      x = EXTREMES[$urandom_range(0, 4)];
      y = EXTREMES[$urandom_range(0, 4)];
      r = EXTREMES[$urandom_range(0, 4)];
    end else begin
      x = VEL_W'($urandom);
      y = VEL_W'($urandom);
      r = VEL_W'($urandom);
    end
    last_zero = (x == 0 && y == 0 && r == 0);
  endfunction

  // Register values: the ends of the range, anywhere, or the low end where speeds
  // mostly stay under the limit.
  function automatic logic [CFG_W-1:0] pick_register(input int top);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_W'(top);
      2, 3:    return CFG_W'($urandom_range(0, top));
      default: return CFG_W'($urandom_range(0, top >> 3));
    endcase
  endfunction

  // Random commands in bursts until enough results are owed; ignored zero repeats
  // do not count toward the target.
  task automatic run_random_phase(input int target);
    int                      made, burst, gap_max;
    bit                      produced;
    logic signed [VEL_W-1:0] x, y, r;
    made    = 0;
    burst   = $urandom_range(1, 16);
    gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    while (made < target) begin
      pick_command(x, y, r);
      send_command(x, y, r, produced);
      if (produced) made++;
      burst--;
      if (burst == 0) begin
        if (gap_max > 0) idle_sender($urandom_range(1, gap_max));
        burst = $urandom_range(1, 16);
      end
    end
    drain();
  endtask

  // Receiver: each stretch is either steady ready or follows a
  // rotating random pattern, dense or sparse. Each pattern has a set bit, so no
  // stall outlasts one turn of the pattern.
  initial begin
    int          stretch, mode;
    logic [15:0] pattern;
    wait (!rst);
    forever begin
      stretch = $urandom_range(20, 200);
      mode    = $urandom_range(0, 2);
      case (mode)
        0:       pattern = 16'hFFFF;
        1:       pattern = 16'($urandom) | 16'd1;
        default: pattern = 16'($urandom & $urandom & $urandom) | 16'd1;
      endcase
      repeat (stretch) begin
        @(negedge clk);
        out_ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // Check each result at the edge that accepts it.
  initial begin
    speed_set_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.action  = action;
        got.ma      = motor_a;
        got.mb      = motor_b;
        got.mc      = motor_c;
        got.md      = motor_d;
        got.limited = limited;
        board.check_speeds(got);
      end
    end
  end

  // Hang detection: any handshake on either channel resets the count.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results still owed", $realtime,
                 quiet_cycles, board.pending_speeds.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: stop handling, unit steps, a non-zero command whose speeds
    // truncate to zero, and the corners of the command space.
    send_command(16'sd0, 16'sd0, 16'sd0, owed);
    send_command(16'sd0, 16'sd0, 16'sd0, owed);
    send_command(16'sd0, 16'sd0, 16'sd0, owed);
    send_command(16'sd16, 16'sd0, 16'sd0, owed);
    send_command(16'sd0, 16'sd16, 16'sd0, owed);
    send_command(16'sd0, 16'sd0, 16'sd4096, owed);
    send_command(16'sd1, 16'sd0, 16'sd0, owed);
    send_command(16'sd0, 16'sd0, 16'sd1, owed);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, owed);
    send_command(16'sh8000, 16'sh8000, 16'sh8000, owed);
    send_command(16'sh7FFF, 16'sh8000, 16'sh8000, owed);
    send_command(-16'sd1, -16'sd1, -16'sd1, owed);
    send_command(16'sd0, 16'sd0, 16'sd0, owed);
    drain();

    // Zero limit: written with bit 15 set, which the register must drop. Every
    // non-zero speed scales to zero. The spare index must change nothing.
    write_register(CFG_SPEED_LIMIT, 16'h8000);
    write_register(CFG_SPARE, 16'hFFFF);
    send_command(16'sd16, 16'sd0, 16'sd0, owed);
    send_command(16'sd0, 16'sd0, 16'sd0, owed);
    send_command(16'sh8000, 16'sh7FFF, 16'sd0, owed);
    drain();

    // Everything at its top.
    write_register(CFG_WHEEL_GEOMETRY, 16'hFFFF);
    write_register(CFG_SPEED_GAIN, 16'hFFFF);
    write_register(CFG_SPEED_LIMIT, 16'h7FFF);
    send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, owed);
    send_command(16'sh8000, 16'sd0, 16'sh8000, owed);
    send_command(16'sd1, 16'sd0, 16'sd1, owed);
    send_command(16'sd0, -16'sd1, 16'sd0, owed);
    drain();

    // Zero geometry and gain: non-zero commands still give action with zero speeds.
    write_register(CFG_WHEEL_GEOMETRY, 16'h0000);
    write_register(CFG_SPEED_GAIN, 16'h0000);
    send_command(16'sd12345, -16'sd321, 16'sh7FFF, owed);
    send_command(16'sd0, 16'sd0, 16'sh8000, owed);
    drain();

    // Random phases; the first restores the defaults, the rest pick new settings.
    for (p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        write_register(CFG_WHEEL_GEOMETRY, WHEEL_GEOMETRY_RST);
        write_register(CFG_SPEED_GAIN, SPEED_GAIN_RST);
        write_register(CFG_SPEED_LIMIT, CFG_W'(SPEED_LIMIT_RST));
      end else begin
        write_register(CFG_WHEEL_GEOMETRY, pick_register(65535));
        write_register(CFG_SPEED_GAIN, pick_register(65535));
        write_register(CFG_SPEED_LIMIT,
                       pick_register(32767) | (CFG_W'($urandom_range(0, 1)) << LIM_W));
        if ($urandom_range(0, 2) == 0) write_register(CFG_SPARE, CFG_W'($urandom));
      end
      run_random_phase(PHASE_ITEMS);
    end

    $display("Ran %0d chassis commands over %0d register settings, %0d results checked.",
             commands_sent, settings_used, board.results_checked);
    $display("Of those, %0d were scaled to the speed limit and %0d were stop results.",
             board.limited_results, board.stop_results);
    if (board.errors == 0 && board.pending_speeds.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d bad results, %0d results never arrived", board.errors,
               board.pending_speeds.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
